// File: design/tlb_pkg.sv
// tlb_pkg: shared widths, opcodes, controller/datapath command and status structs
// no dependencies

package tlb_pkg;

    localparam int COORD_W   = 18;
    localparam int DIFF_W    = 19;
    localparam int PROD_W    = 38;
    localparam int CROSS_W   = 39;
    localparam int MAG_W     = 38;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = 19;
    localparam int REM_W     = MAG_W + FRAC_W;
    localparam int DSH_W     = MAG_W + QUO_W - 1;
    localparam int CNT_W     = 9;
    localparam int SLOT_W    = 8;
    localparam int VNUM_W    = 8;
    localparam int OP_W      = 2;
    localparam int CORNER_W  = 2;
    localparam int IDX_EXT_W = 13;
    localparam int STEP_W    = 5;
    localparam int NUM_CROSS = 6;

    localparam int DEF_MAX_TRIANGLES = 256;
    localparam int DEF_MAX_VERTICES  = 256;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(NUM_CROSS);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(QUO_W - 1);

    localparam logic [OP_W-1:0] OP_VERTEX = 2'd0;
    localparam logic [OP_W-1:0] OP_CORNER = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic [CORNER_W-1:0] CORNER_A = 2'd0;
    localparam logic [CORNER_W-1:0] CORNER_B = 2'd1;
    localparam logic [CORNER_W-1:0] CORNER_C = 2'd2;

    // weight select for the divider
    localparam logic [1:0] WSEL_1 = 2'd0;
    localparam logic [1:0] WSEL_2 = 2'd1;
    localparam logic [1:0] WSEL_3 = 2'd2;

    // cross product slots
    localparam logic [2:0] X_N3 = 3'd0;
    localparam logic [2:0] X_D3 = 3'd1;
    localparam logic [2:0] X_N2 = 3'd2;
    localparam logic [2:0] X_D2 = 3'd3;
    localparam logic [2:0] X_N1 = 3'd4;
    localparam logic [2:0] X_D1 = 3'd5;

    typedef struct packed {
        logic       load_vtx;
        logic       load_crn;
        logic       start_query;
        logic       crn_rd;
        logic       vtx_rd;
        logic [1:0] vtx_sel;
        logic       vtx_lat;
        logic [1:0] lat_sel;
        logic       diff_en;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       sub_en;
        logic [2:0] sub_sel;
        logic       next_tri;
        logic       div_start;
        logic       div_step;
        logic       div_store;
        logic [1:0] div_sel;
        logic       out_hit;
        logic       out_none;
    } tlb_cmd_t;

    typedef struct packed {
        logic limit_zero;
        logic last_tri;
        logic tri_hit;
        logic out_free;
    } tlb_stat_t;

endpackage

// File: design/tlb_datapath.sv
// tlb_datapath: vertex and corner memories, difference/cross product unit,
// serial divider, weight and output registers; depends on tlb_pkg

module tlb_datapath
    import tlb_pkg::*;
#(
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
    parameter int MAX_VERTICES  = DEF_MAX_VERTICES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tlb_cmd_t                   cmd,
    output tlb_stat_t                  stat,
    input  logic [SLOT_W-1:0]          slot,
    input  logic [CORNER_W-1:0]        corner,
    input  logic [VNUM_W-1:0]          vertex_number,
    input  logic signed [COORD_W-1:0]  coord_x,
    input  logic signed [COORD_W-1:0]  coord_y,
    input  logic                       cfg_valid,
    input  logic [CNT_W-1:0]           cfg_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       found,
    output logic [SLOT_W-1:0]          triangle_hit,
    output logic signed [COORD_W-1:0]  weight_first,
    output logic signed [COORD_W-1:0]  weight_second,
    output logic signed [COORD_W-1:0]  weight_third
);

    localparam int TA = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int VA = $clog2(MAX_VERTICES);
    localparam int TW = $clog2(MAX_TRIANGLES + 1);
    localparam int LW = (TW > CNT_W) ? TW : CNT_W;

    localparam logic signed [COORD_W-1:0] W_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] W_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [QUO_W-1:0] Q_POS_MAX = QUO_W'(W_MAX);
    localparam logic [QUO_W-1:0] Q_NEG_MAX = QUO_W'(W_MAX) + QUO_W'(1);

    function automatic logic signed [DIFF_W-1:0] dsub(logic signed [COORD_W-1:0] a,
                                                      logic signed [COORD_W-1:0] b);
        return DIFF_W'(a) - DIFF_W'(b);
    endfunction

    function automatic logic [MAG_W-1:0] mag(logic signed [CROSS_W-1:0] v);
        logic signed [CROSS_W-1:0] a;
        a = v[CROSS_W-1] ? -v : v;
        return a[MAG_W-1:0];
    endfunction

    function automatic logic nonneg(logic signed [CROSS_W-1:0] n,
                                    logic signed [CROSS_W-1:0] d);
        return (n == '0) || (n[CROSS_W-1] == d[CROSS_W-1]);
    endfunction

    // memories, no reset
    logic [VNUM_W-1:0]      crn0_mem [MAX_TRIANGLES];
    logic [VNUM_W-1:0]      crn1_mem [MAX_TRIANGLES];
    logic [VNUM_W-1:0]      crn2_mem [MAX_TRIANGLES];
    logic [2*COORD_W-1:0]   vtx_mem  [MAX_VERTICES];

    logic [VNUM_W-1:0]      c0_reg, c1_reg, c2_reg;
    logic [2*COORD_W-1:0]   vrd_reg;
    logic                   vok_reg;

    logic [IDX_EXT_W-1:0]   slot_ext;
    logic [IDX_EXT_W-1:0]   vnum_ext;
    logic [VNUM_W-1:0]      vsel_num;
    logic [TW-1:0]          t_reg;
    logic [CNT_W-1:0]       count_reg;

    assign slot_ext = IDX_EXT_W'(slot);

    always_comb
    begin
        case (cmd.vtx_sel)
            CORNER_A: vsel_num = c0_reg;
            CORNER_B: vsel_num = c1_reg;
            default:  vsel_num = c2_reg;
        endcase
    end

    assign vnum_ext = IDX_EXT_W'(vsel_num);

    always_ff @(posedge clk)
    begin
        if (cmd.load_vtx && (slot_ext < IDX_EXT_W'(MAX_VERTICES)))
            vtx_mem[slot_ext[VA-1:0]] <= {coord_x, coord_y};
        if (cmd.load_crn && (slot_ext < IDX_EXT_W'(MAX_TRIANGLES)))
        begin
            case (corner)
                CORNER_A: crn0_mem[slot_ext[TA-1:0]] <= vertex_number;
                CORNER_B: crn1_mem[slot_ext[TA-1:0]] <= vertex_number;
                CORNER_C: crn2_mem[slot_ext[TA-1:0]] <= vertex_number;
                default:  ;
            endcase
        end
        if (cmd.crn_rd)
        begin
            c0_reg <= crn0_mem[t_reg[TA-1:0]];
            c1_reg <= crn1_mem[t_reg[TA-1:0]];
            c2_reg <= crn2_mem[t_reg[TA-1:0]];
        end
        if (cmd.vtx_rd)
        begin
            vrd_reg <= vtx_mem[vnum_ext[VA-1:0]];
            vok_reg <= vnum_ext < IDX_EXT_W'(MAX_VERTICES);
        end
    end

    // query point, triangle corners
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic signed [COORD_W-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic signed [COORD_W-1:0] lx, ly;

    assign lx = vok_reg ? vrd_reg[2*COORD_W-1:COORD_W] : '0;
    assign ly = vok_reg ? vrd_reg[COORD_W-1:0] : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.start_query)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (cmd.vtx_lat)
        begin
            case (cmd.lat_sel)
                CORNER_A:
                begin
                    x1_reg <= lx;
                    y1_reg <= ly;
                end
                CORNER_B:
                begin
                    x2_reg <= lx;
                    y2_reg <= ly;
                end
                default:
                begin
                    x3_reg <= lx;
                    y3_reg <= ly;
                end
            endcase
        end
    end

    // edge differences
    logic signed [DIFF_W-1:0] da_reg, db_reg, dc_reg, dd_reg, de_reg, df_reg;
    logic signed [DIFF_W-1:0] dg_reg, dh_reg, di_reg, dj_reg, dk_reg, dl_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.diff_en)
        begin
            da_reg <= dsub(x2_reg, x1_reg);
            db_reg <= dsub(y2_reg, y1_reg);
            dc_reg <= dsub(x3_reg, x1_reg);
            dd_reg <= dsub(y3_reg, y1_reg);
            de_reg <= dsub(px_reg, x1_reg);
            df_reg <= dsub(py_reg, y1_reg);
            dg_reg <= dsub(x2_reg, x3_reg);
            dh_reg <= dsub(y2_reg, y3_reg);
            di_reg <= dsub(px_reg, x3_reg);
            dj_reg <= dsub(py_reg, y3_reg);
            dk_reg <= dsub(x1_reg, x3_reg);
            dl_reg <= dsub(y1_reg, y3_reg);
        end
    end

    // cross = ma*mb - mc*md, two multipliers, one cross per cycle
    logic signed [DIFF_W-1:0]  ma, mb, mc, md;
    logic signed [PROD_W-1:0]  p0_reg, p1_reg;
    logic signed [CROSS_W-1:0] crs_reg [NUM_CROSS];

    always_comb
    begin
        case (cmd.mul_sel)
            X_N3:    begin ma = df_reg; mb = da_reg; mc = de_reg; md = db_reg; end
            X_D3:    begin ma = dd_reg; mb = da_reg; mc = dc_reg; md = db_reg; end
            X_N2:    begin ma = df_reg; mb = dc_reg; mc = de_reg; md = dd_reg; end
            X_D2:    begin ma = db_reg; mb = dc_reg; mc = da_reg; md = dd_reg; end
            X_N1:    begin ma = dj_reg; mb = dg_reg; mc = di_reg; md = dh_reg; end
            default: begin ma = dl_reg; mb = dg_reg; mc = dk_reg; md = dh_reg; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            p0_reg <= ma * mb;
            p1_reg <= mc * md;
        end
        if (cmd.sub_en && (cmd.sub_sel < 3'(NUM_CROSS)))
            crs_reg[cmd.sub_sel] <= CROSS_W'(p0_reg) - CROSS_W'(p1_reg);
    end

    // inside test
    logic nondeg;
    assign nondeg = (crs_reg[X_D1] != '0) && (crs_reg[X_D2] != '0) && (crs_reg[X_D3] != '0);
    assign stat.tri_hit = nondeg && nonneg(crs_reg[X_N1], crs_reg[X_D1])
                                 && nonneg(crs_reg[X_N2], crs_reg[X_D2])
                                 && nonneg(crs_reg[X_N3], crs_reg[X_D3]);

    // restoring divider: quotient of |n|*2^16 / |d|, one bit per step
    logic signed [CROSS_W-1:0] dn, dd;
    logic [REM_W-1:0]          rem_reg;
    logic [DSH_W-1:0]          dsh_reg;
    logic [QUO_W-1:0]          quo_reg;
    logic                      neg_reg;
    logic                      ge;
    logic [QUO_W-1:0]          qneg;
    logic signed [COORD_W-1:0] wsat;
    logic signed [COORD_W-1:0] w1_reg, w2_reg, w3_reg;

    always_comb
    begin
        case (cmd.div_sel)
            WSEL_1:  begin dn = crs_reg[X_N1]; dd = crs_reg[X_D1]; end
            WSEL_2:  begin dn = crs_reg[X_N2]; dd = crs_reg[X_D2]; end
            default: begin dn = crs_reg[X_N3]; dd = crs_reg[X_D3]; end
        endcase
    end

    assign ge   = DSH_W'(rem_reg) >= dsh_reg;
    assign qneg = ~quo_reg + QUO_W'(1);

    always_comb
    begin
        if (neg_reg)
            wsat = (quo_reg > Q_NEG_MAX) ? W_MIN : qneg[COORD_W-1:0];
        else
            wsat = (quo_reg > Q_POS_MAX) ? W_MAX : quo_reg[COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= {mag(dn), {FRAC_W{1'b0}}};
            dsh_reg <= {mag(dd), {(QUO_W-1){1'b0}}};
            quo_reg <= '0;
            neg_reg <= (dn[CROSS_W-1] != dd[CROSS_W-1]) && (dn != '0);
        end
        else if (cmd.div_step)
        begin
            if (ge)
                rem_reg <= rem_reg - dsh_reg[REM_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                WSEL_1:  w1_reg <= wsat;
                WSEL_2:  w2_reg <= wsat;
                default: w3_reg <= wsat;
            endcase
        end
    end

    // scan counter and triangle count register
    logic [LW:0] limit;
    logic [LW:0] t_next_ext;

    assign limit = ((LW+1)'(count_reg) < (LW+1)'(MAX_TRIANGLES)) ?
                   (LW+1)'(count_reg) : (LW+1)'(MAX_TRIANGLES);
    assign t_next_ext      = (LW+1)'(t_reg) + (LW+1)'(1);
    assign stat.last_tri   = t_next_ext >= limit;
    assign stat.limit_zero = limit == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            t_reg     <= '0;
        end
        else
        begin
            if (cfg_valid)
                count_reg <= cfg_data;
            if (cmd.start_query)
                t_reg <= '0;
            else if (cmd.next_tri)
                t_reg <= TW'(t_next_ext);
        end
    end

    // output register
    logic out_valid_reg, out_valid_next;
    logic [IDX_EXT_W-1:0] t_ext;

    assign t_ext         = IDX_EXT_W'(t_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        if (cmd.out_hit || cmd.out_none)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_hit)
        begin
            found         <= 1'b1;
            triangle_hit  <= t_ext[SLOT_W-1:0];
            weight_first  <= w1_reg;
            weight_second <= w2_reg;
            weight_third  <= w3_reg;
        end
        else if (cmd.out_none)
        begin
            found         <= 1'b0;
            triangle_hit  <= '0;
            weight_first  <= '0;
            weight_second <= '0;
            weight_third  <= '0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: design/tlb_control.sv
// tlb_control: sequencer for loads, triangle scan and weight division
// depends on tlb_pkg

module tlb_control
    import tlb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic [OP_W-1:0] opcode,
    output logic            in_ready,
    input  tlb_stat_t       stat,
    output tlb_cmd_t        cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CRN      = 4'd1;
    localparam logic [3:0] S_V0       = 4'd2;
    localparam logic [3:0] S_V1       = 4'd3;
    localparam logic [3:0] S_V2       = 4'd4;
    localparam logic [3:0] S_V3       = 4'd5;
    localparam logic [3:0] S_DIFF     = 4'd6;
    localparam logic [3:0] S_MUL      = 4'd7;
    localparam logic [3:0] S_EVAL     = 4'd8;
    localparam logic [3:0] S_DSTART   = 4'd9;
    localparam logic [3:0] S_DSTEP    = 4'd10;
    localparam logic [3:0] S_DSTORE   = 4'd11;
    localparam logic [3:0] S_OUT_HIT  = 4'd12;
    localparam logic [3:0] S_OUT_NONE = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [1:0]        dsel_reg, dsel_next;
    logic [STEP_W-1:0] step_prev;

    assign in_ready  = state_reg == S_IDLE;
    assign step_prev = step_reg - STEP_W'(1);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        dsel_next  = dsel_reg;
        cmd        = '0;
        cmd.div_sel = dsel_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (opcode)
                        OP_VERTEX: cmd.load_vtx = 1'b1;
                        OP_CORNER: cmd.load_crn = 1'b1;
                        OP_QUERY:
                        begin
                            cmd.start_query = 1'b1;
                            state_next = stat.limit_zero ? S_OUT_NONE : S_CRN;
                        end
                        default: ;
                    endcase
                end
            end
            S_CRN:
            begin
                cmd.crn_rd = 1'b1;
                state_next = S_V0;
            end
            S_V0:
            begin
                cmd.vtx_rd  = 1'b1;
                cmd.vtx_sel = CORNER_A;
                state_next  = S_V1;
            end
            S_V1:
            begin
                cmd.vtx_lat = 1'b1;
                cmd.lat_sel = CORNER_A;
                cmd.vtx_rd  = 1'b1;
                cmd.vtx_sel = CORNER_B;
                state_next  = S_V2;
            end
            S_V2:
            begin
                cmd.vtx_lat = 1'b1;
                cmd.lat_sel = CORNER_B;
                cmd.vtx_rd  = 1'b1;
                cmd.vtx_sel = CORNER_C;
                state_next  = S_V3;
            end
            S_V3:
            begin
                cmd.vtx_lat = 1'b1;
                cmd.lat_sel = CORNER_C;
                state_next  = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff_en = 1'b1;
                step_next   = '0;
                state_next  = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en  = step_reg < MUL_LAST;
                cmd.mul_sel = step_reg[2:0];
                cmd.sub_en  = step_reg != '0;
                cmd.sub_sel = step_prev[2:0];
                if (step_reg == MUL_LAST)
                    state_next = S_EVAL;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_EVAL:
            begin
                if (stat.tri_hit)
                begin
                    dsel_next  = WSEL_1;
                    state_next = S_DSTART;
                end
                else if (stat.last_tri)
                    state_next = S_OUT_NONE;
                else
                begin
                    cmd.next_tri = 1'b1;
                    state_next   = S_CRN;
                end
            end
            S_DSTART:
            begin
                cmd.div_start = 1'b1;
                step_next     = '0;
                state_next    = S_DSTEP;
            end
            S_DSTEP:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == DIV_LAST)
                    state_next = S_DSTORE;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_DSTORE:
            begin
                cmd.div_store = 1'b1;
                if (dsel_reg == WSEL_3)
                    state_next = S_OUT_HIT;
                else
                begin
                    dsel_next  = dsel_reg + 2'd1;
                    state_next = S_DSTART;
                end
            end
            S_OUT_HIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_hit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_OUT_NONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_none = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            dsel_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            dsel_reg  <= dsel_next;
        end
    end

endmodule

// File: design/triangle_locate_barycentric.sv
// triangle_locate_barycentric: top level, point-in-triangle search by barycentric weights
// depends on tlb_pkg, tlb_control, tlb_datapath
//
// channel | direction | handshake           | payload
// --------+-----------+---------------------+---------------------------------------------
// in      | input     | in_valid / in_ready | opcode slot corner vertex_number coord_x/y
// out     | output    | out_valid/out_ready | found triangle_hit weight_first/second/third
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (triangle_count)
//
// loads (vertex or triangle corner) keep in_ready high and give no transaction on out
// a query scans the triangles in turn (corner read, vertex reads, differences, cross products,
//   inside test), then runs three 19-step serial divisions when a containing triangle is found
// the per-triangle scan is paced by the memory read chain and the shared multiplier pair
// one item at a time: in_ready drops during a query and returns once its result is registered
// a result waiting on out does not block loads; a later query holds at its end until out is free
// reset clears control and triangle_count; the vertex and corner memories are not cleared

module triangle_locate_barycentric
    import tlb_pkg::*;
#(
    parameter int MAX_TRIANGLES = DEF_MAX_TRIANGLES,
    parameter int MAX_VERTICES  = DEF_MAX_VERTICES
) (
    input  logic                      clk,
    input  logic                      rst_n,
    // input item channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [OP_W-1:0]           opcode,
    input  logic [SLOT_W-1:0]         slot,
    input  logic [CORNER_W-1:0]       corner,
    input  logic [VNUM_W-1:0]         vertex_number,
    input  logic signed [COORD_W-1:0] coord_x,
    input  logic signed [COORD_W-1:0] coord_y,
    // result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      found,
    output logic [SLOT_W-1:0]         triangle_hit,
    output logic signed [COORD_W-1:0] weight_first,
    output logic signed [COORD_W-1:0] weight_second,
    output logic signed [COORD_W-1:0] weight_third,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CNT_W-1:0]          cfg_data
);

    tlb_cmd_t  cmd;
    tlb_stat_t stat;

    // the count register takes a write in any cycle
    assign cfg_ready = 1'b1;

    // sequencer: decodes loads in the accept cycle, walks the triangle scan and the weight divisions
    tlb_control u_control (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // memories, cross products, divider and output register
    tlb_datapath #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .MAX_VERTICES  (MAX_VERTICES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .slot          (slot),
        .corner        (corner),
        .vertex_number (vertex_number),
        .coord_x       (coord_x),
        .coord_y       (coord_y),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .out_valid     (out_valid),
        .found         (found),
        .triangle_hit  (triangle_hit),
        .weight_first  (weight_first),
        .weight_second (weight_second),
        .weight_third  (weight_third)
    );

endmodule

// File: design/tlb_checker.sv
// tlb_checker: port-level assertions for triangle_locate_barycentric, bound to the top level
// depends on tlb_pkg

module tlb_checker
    import tlb_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic [OP_W-1:0]           opcode,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic                      found,
    input logic [SLOT_W-1:0]         triangle_hit,
    input logic signed [COORD_W-1:0] weight_first,
    input logic signed [COORD_W-1:0] weight_second,
    input logic signed [COORD_W-1:0] weight_third
);

    // a pending result transaction is held
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transaction");

    // a miss reports all zero
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> triangle_hit == '0 && weight_first == '0
                                && weight_second == '0 && weight_third == '0)
        else $error("miss result not zero");

    // a hit has no negative weight
    a_hit_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> !weight_first[COORD_W-1] && !weight_second[COORD_W-1]
                               && !weight_third[COORD_W-1])
        else $error("negative weight on hit");

    // a query occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_QUERY |=> !in_ready)
        else $error("input taken during query");

    // results appear only from a running query
    a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without query");

endmodule

bind triangle_locate_barycentric tlb_checker u_tlb_checker (.*);
